/* rtl/veg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package veg_pkg;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_NOTE_ON  = 3'd1,
        CMD_NOTE_OFF = 3'd2,
        CMD_ALL_OFF  = 3'd3,
        CMD_FINISHED = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_VARIANT = 2'd0,
        CFG_MASTER  = 2'd1,
        CFG_PLAY    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VAR_DIRECT   = 2'd0,
        VAR_MASTER_V = 2'd1,
        VAR_MASTER   = 2'd2
    } t_variant;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_RELOAD,
        S_OUT
    } t_state;

    localparam logic [2:0] STG_IDLE    = 3'd0;
    localparam logic [2:0] STG_FIRST   = 3'd1;
    localparam logic [2:0] STG_SUSTAIN = 3'd3;
    localparam logic [2:0] STG_RELEASE = 3'd4;
    localparam logic [2:0] STG_END     = 3'd6;

    localparam logic [5:0] VOL_MAX     = 6'd63;
    localparam logic [7:0] LEVEL_START = 8'd64;

endpackage

`default_nettype wire

/* rtl/veg_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module veg_mul (
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic [5:0]  i_a,
    input  wire logic [5:0]  i_b,
    output logic      [11:0] o_prod
);

    logic [11:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= {6'd0, i_a} * {6'd0, i_b};
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* rtl/voice_envelope_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Envelope unit for one voice. Commands (tick, note on, note off, all notes
// off, playback finished) arrive one at a time; each gives exactly one result
// with stop/start flags, an optional channel volume and the stage afterward.
// A command passes through the evaluation, multiply and output states, its result
// being registered on leaving the output state. Every tick in the master-scaled-with-
// velocity variant also passes through a reload state and the multiply once more,
// since its volume scaling passes twice through the single 6x6 multiplier. The input is
// stalled while a command is in work and while a finished result waits for a
// stalled output register; once the result is in that register, a new request
// can be taken while it waits. Configuration writes are always ready and
// belong in idle periods.
module voice_envelope_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [6:0]  i_note,
    input  wire logic [6:0]  i_velocity,
    input  wire logic        i_instrument_present,
    input  wire logic        i_looped,
    input  wire logic [31:0] i_skip_word,
    input  wire logic [31:0] i_step_word,
    input  wire logic [31:0] i_target_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_stop_voice,
    output logic             o_start_voice,
    output logic             o_start_looped,
    output logic             o_volume_valid,
    output logic      [5:0]  o_volume,
    output logic      [2:0]  o_stage,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    import veg_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [1:0] r_variant;
    logic [3:0] r_master;
    logic       r_play;

    // latched request
    logic [2:0]  r_cmd;
    logic [6:0]  r_note;
    logic [6:0]  r_vel;
    logic        r_present;
    logic        r_looped;
    logic [31:0] r_in_skip, r_in_step, r_in_tgt;

    // envelope state
    logic [2:0]  r_stage, n_stage;
    logic [7:0]  r_cd, n_cd;
    logic [7:0]  r_level, n_level;
    logic [6:0]  r_held, n_held;
    logic        r_held_vld, n_held_vld;
    logic [5:0]  r_vl, n_vl;
    logic [31:0] r_tab_skip, r_tab_step, r_tab_tgt;
    logic [31:0] n_tab_skip, n_tab_step, n_tab_tgt;

    // pending result
    logic r_res_stop, r_res_start, r_res_sloop, r_res_vvld;
    logic n_res_stop, n_res_start, n_res_sloop, n_res_vvld;

    // multiplier control
    logic [5:0] r_ma, r_mb, n_ma, n_mb;
    logic       r_two, n_two;
    logic       r_shr6, n_shr6;
    logic [11:0] prod;

    // output register
    logic       r_out_valid;
    logic       r_o_stop, r_o_start, r_o_sloop, r_o_vvld;
    logic [5:0] r_o_vol;
    logic [2:0] r_o_stage;

    logic in_take, mul_load, out_load, out_free;

    // tick helpers
    logic [2:0]        idx_w;
    logic [1:0]        idx;
    logic [7:0]        skip_b, step_b, tgt_b;
    logic              cur_pos;
    logic [5:0]        v_tick;
    logic [7:0]        diff;
    logic signed [9:0] nv_ext, tgt_ext;
    logic              reach;
    logic [5:0]        v_in;
    logic              is_tick;
    logic              off_hit;
    logic [6:0]        off_note;
    logic              do_off;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EVAL;
            S_EVAL:   n_state = S_MUL;
            S_MUL:    n_state = r_two ? S_RELOAD : S_OUT;
            S_RELOAD: n_state = S_MUL;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        mul_load   = (r_state == S_MUL);
        out_load   = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VAR_DIRECT;
            r_master  <= 4'd15;
            r_play    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VARIANT: r_variant <= i_cfg_data[1:0];
                CFG_MASTER:  r_master  <= i_cfg_data;
                CFG_PLAY:    r_play    <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    // ---------------- request latch ----------------
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd     <= i_cmd;
            r_note    <= i_note;
            r_vel     <= i_velocity;
            r_present <= i_instrument_present;
            r_looped  <= i_looped;
            r_in_skip <= i_skip_word;
            r_in_step <= i_step_word;
            r_in_tgt  <= i_target_word;
        end
    end

    // ---------------- evaluation ----------------
    // stages 1,2 use entries 0,1; release stages 4,5 use entries 2,3
    assign idx_w  = (r_stage > STG_SUSTAIN) ? (r_stage - 3'd2) : (r_stage - 3'd1);
    assign idx    = idx_w[1:0];
    assign skip_b = r_tab_skip[8*idx +: 8];
    assign step_b = r_tab_step[8*idx +: 8];
    assign tgt_b  = r_tab_tgt[8*idx +: 8];

    assign cur_pos = !r_level[7] && (r_level != 8'd0);
    assign v_tick  = !r_play ? 6'd0 : (r_level[6] ? VOL_MAX : r_level[5:0]);
    assign diff    = r_level - step_b;
    assign nv_ext  = {{2{diff[7]}}, diff};
    assign tgt_ext = {2'b00, tgt_b};
    assign reach   = step_b[7] ? (nv_ext > tgt_ext) : (nv_ext < tgt_ext);

    assign is_tick = (t_cmd'(r_cmd) == CMD_TICK);
    assign v_in    = is_tick ? v_tick : VOL_MAX;

    // note-off path, shared by note off, zero-velocity note on and all notes off
    always_comb begin
        do_off   = 1'b0;
        off_note = r_note;
        case (t_cmd'(r_cmd))
            CMD_NOTE_ON:  do_off = (r_vel == 7'd0);
            CMD_NOTE_OFF: do_off = 1'b1;
            CMD_ALL_OFF: begin
                do_off   = (r_stage < STG_RELEASE);
                off_note = r_held;
            end
            default: do_off = 1'b0;
        endcase
    end
    assign off_hit = do_off && r_held_vld && (r_held == off_note);

    always_comb begin
        n_stage     = r_stage;
        n_cd        = r_cd;
        n_level     = r_level;
        n_held      = r_held;
        n_held_vld  = r_held_vld;
        n_vl        = r_vl;
        n_tab_skip  = r_tab_skip;
        n_tab_step  = r_tab_step;
        n_tab_tgt   = r_tab_tgt;
        n_res_stop  = 1'b0;
        n_res_start = 1'b0;
        n_res_sloop = 1'b0;
        n_res_vvld  = 1'b0;

        if (off_hit) begin
            if (r_stage != STG_IDLE) begin
                if (r_variant == VAR_DIRECT) n_cd = 8'd0;
                else n_level = r_tab_tgt[15:8];
                n_stage = STG_RELEASE;
            end
            n_held_vld = 1'b0;
        end else begin
            case (t_cmd'(r_cmd))
                CMD_TICK: begin
                    if (r_stage == STG_END) begin
                        n_res_stop = 1'b1;
                        n_stage    = STG_IDLE;
                    end else if (r_stage != STG_IDLE && r_stage != STG_SUSTAIN) begin
                        if (r_cd == 8'd0) begin
                            if (!cur_pos) begin
                                n_res_stop = 1'b1;
                                n_stage    = STG_IDLE;
                                n_cd       = skip_b;
                            end else begin
                                n_cd       = skip_b - 8'd1;
                                n_res_vvld = 1'b1;
                                if (reach) begin
                                    n_level = tgt_b;
                                    n_stage = r_stage + 3'd1;
                                end else begin
                                    n_level = diff;
                                end
                            end
                        end else begin
                            n_cd = r_cd - 8'd1;
                        end
                    end
                end
                CMD_NOTE_ON: begin
                    if (r_vel != 7'd0) begin
                        n_res_stop = 1'b1;
                        n_stage    = STG_IDLE;
                        if (r_variant != VAR_DIRECT || r_present) begin
                            n_tab_skip  = r_in_skip;
                            n_tab_step  = r_in_step;
                            n_tab_tgt   = r_in_tgt;
                            n_vl        = r_vel[6:1];
                            n_held      = r_note;
                            n_held_vld  = 1'b1;
                            n_res_start = 1'b1;
                            n_res_sloop = r_looped;
                            if (r_variant == VAR_DIRECT) begin
                                n_level    = LEVEL_START;
                                n_cd       = 8'd0;
                                n_res_vvld = 1'b1;
                                if (r_looped) n_stage = STG_FIRST;
                            end else begin
                                n_res_vvld = r_play;
                                if (r_in_skip[7:0] != 8'd0 && r_looped) begin
                                    n_level = {2'b00, r_vel[6:1]};
                                    n_cd    = 8'd0;
                                    n_stage = STG_FIRST;
                                end
                            end
                        end
                    end
                end
                CMD_FINISHED: n_stage = STG_IDLE;
                default: ;
            endcase
        end
    end

    // multiplier operands for the volume
    always_comb begin
        n_ma   = v_in;
        n_mb   = n_vl;
        n_two  = 1'b0;
        n_shr6 = 1'b1;
        if (!is_tick && r_variant != VAR_DIRECT) begin
            // non-tick commands (the note on volume) in master-scaled variants: master * voice level >> 4
            n_ma   = {2'b00, r_master};
            n_shr6 = 1'b0;
        end else begin
            case (t_variant'(r_variant))
                VAR_DIRECT: begin
                    if (r_master == 4'd0 || !r_play) n_ma = 6'd0;
                end
                VAR_MASTER_V: begin
                    n_mb  = {2'b00, r_master};
                    n_two = 1'b1;
                end
                default: begin
                    n_mb   = {2'b00, r_master};
                    n_shr6 = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= STG_IDLE;
            r_cd       <= 8'd0;
            r_level    <= 8'd0;
            r_held     <= 7'd0;
            r_held_vld <= 1'b0;
            r_vl       <= 6'd0;
            r_tab_skip <= 32'd0;
            r_tab_step <= 32'd0;
            r_tab_tgt  <= 32'd0;
        end else if (r_state == S_EVAL) begin
            r_stage    <= n_stage;
            r_cd       <= n_cd;
            r_level    <= n_level;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_vl       <= n_vl;
            r_tab_skip <= n_tab_skip;
            r_tab_step <= n_tab_step;
            r_tab_tgt  <= n_tab_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two <= 1'b0;
        end else if (r_state == S_EVAL) begin
            r_two <= n_two;
        end else if (r_state == S_RELOAD) begin
            r_two <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_ma        <= n_ma;
            r_mb        <= n_mb;
            r_shr6      <= n_shr6;
            r_res_stop  <= n_res_stop;
            r_res_start <= n_res_start;
            r_res_sloop <= n_res_sloop;
            r_res_vvld  <= n_res_vvld;
        end else if (r_state == S_RELOAD) begin
            // second pass: (v * master >> 4) * voice level
            r_ma <= prod[9:4];
            r_mb <= r_vl;
        end
    end

    veg_mul u_mul (
        .i_clk  (i_clk),
        .i_load (mul_load),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_prod (prod)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_stop  <= r_res_stop;
            r_o_start <= r_res_start;
            r_o_sloop <= r_res_sloop;
            r_o_vvld  <= r_res_vvld;
            r_o_stage <= r_stage;
            if (!r_res_vvld) r_o_vol <= 6'd0;
            else if (r_shr6) r_o_vol <= prod[11:6];
            else r_o_vol <= prod[9:4];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_stop_voice   = r_o_stop;
    assign o_start_voice  = r_o_start;
    assign o_start_looped = r_o_sloop;
    assign o_volume_valid = r_o_vvld;
    assign o_volume       = r_o_vol;
    assign o_stage        = r_o_stage;

endmodule

`default_nettype wire

/* tb/voice_envelope_generator_tb.sv */
`timescale 1ns / 1ps

module voice_envelope_generator_tb;
    import veg_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 125;
    localparam int END_CYCLES    = 10;

    // codes the block must ignore or treat as an alias
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam logic [1:0] VAR_UNUSED    = 2'd3;

    typedef enum {W_SKIP, W_STEP, W_TARGET} t_word_sel;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic        present;
        logic        looped;
        logic [31:0] skip_word;
        logic [31:0] step_word;
        logic [31:0] target_word;
    } t_voice_request;

    typedef struct packed {
        logic       stop_voice;
        logic       start_voice;
        logic       start_looped;
        logic       volume_valid;
        logic [5:0] volume;
        logic [2:0] stage;
    } t_voice_result;

    class envelope_scoreboard;
        logic [1:0]  variant;
        logic [3:0]  master_vol;
        logic        play_on;
        logic [2:0]  stage;
        logic [7:0]  countdown;
        logic [7:0]  level;
        logic [6:0]  held_note;
        logic        note_held;
        logic [5:0]  voice_level;
        logic [31:0] skips, steps, targets;
        t_voice_result expected_results[$];
        int mismatches;

        function new();
            variant     = VAR_DIRECT;
            master_vol  = 4'd15;
            play_on     = 1'b1;
            stage       = STG_IDLE;
            countdown   = '0;
            level       = '0;
            held_note   = '0;
            note_held   = 1'b0;
            voice_level = '0;
            skips       = '0;
            steps       = '0;
            targets     = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            if (idx == CFG_VARIANT) variant = data[1:0];
            else if (idx == CFG_MASTER) master_vol = data;
            else if (idx == CFG_PLAY) play_on = data[0];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int scale(int v);
            case (variant)
                VAR_DIRECT: begin
                    if (master_vol == 0 || !play_on) v = 0;
                    return (v * int'(voice_level)) >> 6;
                end
                VAR_MASTER_V: return (((v * int'(master_vol)) >> 4) * int'(voice_level)) >> 6;
                default: return (v * int'(master_vol)) >> 4;
            endcase
        endfunction

        function void release_note(logic [6:0] n);
            if (note_held && held_note == n) begin
                if (stage != STG_IDLE) begin
                    if (variant == VAR_DIRECT) countdown = '0;
                    else level = targets[15:8];
                    stage = STG_RELEASE;
                end
                note_held = 1'b0;
            end
        endfunction

        function void latch_note(t_voice_request req);
            skips       = req.skip_word;
            steps       = req.step_word;
            targets     = req.target_word;
            voice_level = req.velocity[6:1];
            held_note   = req.note;
            note_held   = 1'b1;
        endfunction

        function void accept_request(t_voice_request req);
            t_voice_result res;
            int idx, cur, step_v, tgt, v, nv;
            bit done;
            res = '0;
            case (req.cmd)
                CMD_TICK: begin
                    if (stage == STG_END) begin
                        res.stop_voice = 1'b1;
                        stage = STG_IDLE;
                    end else if (stage != STG_IDLE && stage != STG_SUSTAIN) begin
                        done = 1'b0;
                        if (countdown == 0) begin
                            // release stages use the upper two table bytes
                            idx = int'(stage) - ((stage > STG_SUSTAIN) ? 2 : 1);
                            cur = $signed(level);
                            countdown = skips[8*idx +: 8];
                            if (cur <= 0) begin
                                res.stop_voice = 1'b1;
                                stage = STG_IDLE;
                                done = 1'b1;
                            end else begin
                                step_v = $signed(steps[8*idx +: 8]);
                                tgt    = targets[8*idx +: 8];
                                v = (cur > 63) ? 63 : cur;
                                if (!play_on) v = 0;
                                res.volume_valid = 1'b1;
                                res.volume = 6'(scale(v));
                                level = 8'(cur - step_v);
                                nv = $signed(level);
                                if (step_v < 0 ? (nv > tgt) : (nv < tgt)) begin
                                    level = 8'(tgt);
                                    stage = stage + 3'd1;
                                end
                            end
                        end
                        if (!done) countdown = countdown - 8'd1;
                    end
                end
                CMD_NOTE_ON: begin
                    if (req.velocity == 0) begin
                        release_note(req.note);
                    end else if (variant == VAR_DIRECT) begin
                        res.stop_voice = 1'b1;
                        stage = STG_IDLE;
                        if (req.present) begin
                            latch_note(req);
                            level = LEVEL_START;
                            countdown = '0;
                            if (req.looped) stage = STG_FIRST;
                            res.start_voice  = 1'b1;
                            res.start_looped = req.looped;
                            res.volume_valid = 1'b1;
                            res.volume = 6'(scale(VOL_MAX));
                        end
                    end else begin
                        latch_note(req);
                        res.stop_voice = 1'b1;
                        stage = STG_IDLE;
                        if (skips[7:0] != 0 && req.looped) begin
                            level = {2'b00, voice_level};
                            countdown = '0;
                            stage = STG_FIRST;
                        end
                        res.start_voice  = 1'b1;
                        res.start_looped = req.looped;
                        if (play_on) begin
                            res.volume_valid = 1'b1;
                            res.volume = 6'((int'(master_vol) * int'(voice_level)) >> 4);
                        end
                    end
                end
                CMD_NOTE_OFF: release_note(req.note);
                CMD_ALL_OFF: if (note_held && stage < STG_RELEASE) release_note(held_note);
                CMD_FINISHED: stage = STG_IDLE;
                default: ;
            endcase
            res.stage = stage;
            expected_results = {expected_results, res};
        endfunction

        function void compare_field(string field_name, int expected_v, int actual_v);
            if (expected_v != actual_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field_name, expected_v, actual_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_voice_result got);
            t_voice_result exp_r;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual stage %0d",
                         $time, got.stage);
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("stop_voice", exp_r.stop_voice, got.stop_voice);
            compare_field("start_voice", exp_r.start_voice, got.start_voice);
            compare_field("start_looped", exp_r.start_looped, got.start_looped);
            compare_field("volume_valid", exp_r.volume_valid, got.volume_valid);
            compare_field("volume", exp_r.volume, got.volume);
            compare_field("stage", exp_r.stage, got.stage);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_cmd = '0;
    logic [6:0]  i_note = '0;
    logic [6:0]  i_velocity = '0;
    logic        i_instrument_present = 1'b0;
    logic        i_looped = 1'b0;
    logic [31:0] i_skip_word = '0;
    logic [31:0] i_step_word = '0;
    logic [31:0] i_target_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_stop_voice;
    logic        o_start_voice;
    logic        o_start_looped;
    logic        o_volume_valid;
    logic [5:0]  o_volume;
    logic [2:0]  o_stage;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;

    envelope_scoreboard env_board;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int idle_cycles = 0;

    voice_envelope_generator dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cmd                (i_cmd),
        .i_note               (i_note),
        .i_velocity           (i_velocity),
        .i_instrument_present (i_instrument_present),
        .i_looped             (i_looped),
        .i_skip_word          (i_skip_word),
        .i_step_word          (i_step_word),
        .i_target_word        (i_target_word),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_stop_voice         (o_stop_voice),
        .o_start_voice        (o_start_voice),
        .o_start_looped       (o_start_looped),
        .o_volume_valid       (o_volume_valid),
        .o_volume             (o_volume),
        .o_stage              (o_stage),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // sample every handshake at the edge, then draw the next stall
    always @(posedge i_clk) begin : monitor
        bit moved;
        t_voice_request req;
        t_voice_result got;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                env_board.write_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                req = '{i_cmd, i_note, i_velocity, i_instrument_present, i_looped,
                        i_skip_word, i_step_word, i_target_word};
                env_board.accept_request(req);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_stop_voice, o_start_voice, o_start_looped, o_volume_valid,
                        o_volume, o_stage};
                env_board.check_result(got);
                moved = 1'b1;
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("voice_envelope_generator_tb failed");
            $finish;
        end
    end

    function automatic t_voice_request make_request(logic [2:0] cmd, logic [6:0] note,
                                                    logic [6:0] vel, logic present,
                                                    logic looped, logic [31:0] skip_w,
                                                    logic [31:0] step_w,
                                                    logic [31:0] target_w);
        return '{cmd, note, vel, present, looped, skip_w, step_w, target_w};
    endfunction

    function automatic logic [31:0] random_word(t_word_sel sel);
        logic [31:0] w;
        int k, mag;
        if ($urandom_range(7) == 0) return $urandom();
        for (k = 0; k < 4; k++) begin
            case (sel)
                W_SKIP: w[8*k +: 8] = ($urandom_range(15) == 0) ? 8'd0 :
                                      8'($urandom_range(1, 3));
                W_STEP: begin
                    mag = $urandom_range(1, 40);
                    w[8*k +: 8] = $urandom_range(1) ? 8'(-mag) : 8'(mag);
                end
                default: w[8*k +: 8] = ($urandom_range(7) == 0) ?
                                       8'($urandom_range(128, 255)) :
                                       8'($urandom_range(127));
            endcase
        end
        return w;
    endfunction

    function automatic t_voice_request random_request();
        t_voice_request r;
        int pick;
        r.cmd         = CMD_TICK;
        r.note        = 7'($urandom());
        r.velocity    = 7'($urandom_range(1, 127));
        r.present     = ($urandom_range(9) != 0);
        r.looped      = ($urandom_range(4) != 0);
        r.skip_word   = random_word(W_SKIP);
        r.step_word   = random_word(W_STEP);
        r.target_word = random_word(W_TARGET);
        pick = $urandom_range(99);
        if (pick < 55) begin
            r.cmd = CMD_TICK;
        end else if (pick < 70) begin
            r.cmd = CMD_NOTE_ON;
            if ($urandom_range(9) == 0) begin
                // zero velocity acts as a release of the held note
                r.velocity = '0;
                if (env_board.note_held) r.note = env_board.held_note;
            end
        end else if (pick < 80) begin
            r.cmd = CMD_NOTE_OFF;
            if (env_board.note_held && $urandom_range(3) != 0) r.note = env_board.held_note;
        end else if (pick < 86) begin
            r.cmd = CMD_ALL_OFF;
        end else if (pick < 92) begin
            r.cmd = CMD_FINISHED;
        end else if (pick < 96) begin
            r.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return r;
    endfunction

    task automatic send_request(input t_voice_request req);
        int gap;
        i_in_valid           <= 1'b1;
        i_cmd                <= req.cmd;
        i_note               <= req.note;
        i_velocity           <= req.velocity;
        i_instrument_present <= req.present;
        i_looped             <= req.looped;
        i_skip_word          <= req.skip_word;
        i_step_word          <= req.step_word;
        i_target_word        <= req.target_word;
        do @(posedge i_clk); while (o_in_stall);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (env_board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [3:0] variant_data, input logic [3:0] master_data,
                                  input logic [3:0] play_data, input bit touch_unused);
        logic [1:0] idx_list [4];
        logic [3:0] data_list [4];
        int n, k;
        idx_list  = '{CFG_VARIANT, CFG_MASTER, CFG_PLAY, CFG_UNUSED};
        data_list = '{variant_data, master_data, play_data, 4'($urandom_range(15))};
        n = touch_unused ? 4 : 3;
        for (k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= data_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [1:0] variant_seq [4];
        logic [31:0] env_skips, env_steps, env_targets;
        logic [3:0] master_data;
        int seg;
        variant_seq = '{VAR_DIRECT, VAR_MASTER_V, VAR_MASTER, VAR_UNUSED};
        // attack to 108, decay to 48, sustain, release through zero
        env_skips   = 32'h01_01_02_01;
        env_steps   = 32'h08_08_10_F0;
        env_targets = 32'h00_00_30_6C;
        env_board = new();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_request(CMD_TICK, 7'd0, 7'd0, 1'b0, 1'b0, '0, '0, '0));
        send_request(make_request(CMD_NOTE_ON, 7'd127, 7'd127, 1'b1, 1'b1,
                                  env_skips, env_steps, env_targets));
        repeat (5) send_request(make_request(CMD_TICK, 7'd0, 7'd0, 1'b0, 1'b0,
                                             '1, '1, '1));
        send_request(make_request(CMD_NOTE_OFF, 7'd3, 7'd0, 1'b0, 1'b0, '0, '0, '0));
        send_request(make_request(CMD_ALL_OFF, 7'd0, 7'd0, 1'b0, 1'b0, '0, '0, '0));
        repeat (3) send_request(make_request(CMD_TICK, 7'd0, 7'd0, 1'b0, 1'b0,
                                             '0, '0, '0));
        // no instrument: stop without a start
        send_request(make_request(CMD_NOTE_ON, 7'd0, 7'd1, 1'b0, 1'b1, '1, '1, '1));
        send_request(make_request(CMD_NOTE_ON, 7'd0, 7'd2, 1'b1, 1'b0,
                                  '1, 32'h7F7F7F7F, '1));
        send_request(make_request(CMD_NOTE_ON, 7'd0, 7'd0, 1'b1, 1'b1, '0, '0, '0));
        send_request(make_request(CMD_UNUSED_LO, 7'd127, 7'd127, 1'b1, 1'b1, '1, '1, '1));
        send_request(make_request(CMD_UNUSED_HI, 7'd127, 7'd127, 1'b1, 1'b1, '1, '1, '1));
        // target above 127 wraps negative once stored
        send_request(make_request(CMD_NOTE_ON, 7'd64, 7'd127, 1'b1, 1'b1,
                                  32'h01010101, 32'h01010101, 32'hFFFFFFC8));
        repeat (3) send_request(make_request(CMD_TICK, 7'd0, 7'd0, 1'b0, 1'b0,
                                             '0, '0, '0));
        send_request(make_request(CMD_NOTE_ON, 7'd5, 7'd100, 1'b1, 1'b1,
                                  env_skips, env_steps, env_targets));
        send_request(make_request(CMD_FINISHED, 7'd0, 7'd0, 1'b0, 1'b0, '0, '0, '0));
        send_request(make_request(CMD_TICK, 7'd0, 7'd0, 1'b0, 1'b0, '0, '0, '0));

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg % 3)
                0: master_data = 4'd15;
                1: master_data = 4'd0;
                default: master_data = 4'($urandom_range(1, 14));
            endcase
            apply_settings({2'($urandom_range(3)), variant_seq[seg % 4]}, master_data,
                           {3'($urandom_range(7)), 1'(seg % 5 != 2)}, seg == 7);
            case (seg / 3)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 62; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 62; end
                default: begin in_idle_pct = 12; out_stall_pct = 12; end
            endcase
            repeat (SEGMENT_ITEMS) send_request(random_request());
        end

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (env_board.mismatches == 0) begin
            $display("voice_envelope_generator_tb passed");
        end else begin
            $display("voice_envelope_generator_tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/veg_pkg.sv
rtl/veg_mul.sv
rtl/voice_envelope_generator.sv
tb/voice_envelope_generator_tb.sv
